/* design/lpsht_pkg.sv */
// ----------------------------------------------------------------------------
// lpsht_pkg
// Shared types and codes for the linear probing string hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package lpsht_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_FIND   = 1'b1;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_FOUND     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_TOO_LONG  = 3'd4
	} status_e;

	typedef struct packed {
		logic       op;
		logic [7:0] ch;
		logic       last;
	} key_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] probe_length;
		logic [6:0] slot;
	} res_item_t;

	// controller to datapath
	typedef struct packed {
		logic    clr_wr;
		logic    collect;
		logic    probe_load;
		logic    probe_adv;
		logic    key_wr;
		logic    emit;
		status_e status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic too_long;
		logic op;
		logic used;
		logic match;
		logic probe_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

/* design/lpsht_dp.sv */
// ----------------------------------------------------------------------------
// lpsht_dp
// Key collector, hash, probe pointer, slot memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsht_dp
	import lpsht_pkg::*;
#(
	parameter int TABLE_SIZE = 128,
	parameter int KEY_CHARS  = 14
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire key_item_t key_item,
	input  wire logic      res_stall,
	output logic           res_valid,
	output res_item_t      res_item,
	input  wire cmd_t      cmd,
	output sts_t           sts
);

	localparam int IW = $clog2(TABLE_SIZE);
	localparam int CW = $clog2(KEY_CHARS + 1);
	localparam int KW = 8 * KEY_CHARS;
	localparam int EW = KW + 1;
	localparam logic [IW-1:0] LAST_IDX  = IW'(TABLE_SIZE - 1);
	localparam logic [IW:0]   TSIZE_EXT = (IW + 1)'(TABLE_SIZE);

	// key collector
	logic          op_q;
	logic          too_long_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] hash_q;
	logic [KW-1:0] key_buf_q;

	// probe walk
	logic [IW-1:0] pos_q;
	logic [IW-1:0] n_q;

	logic [EW-1:0] mem_q [TABLE_SIZE];
	logic [EW-1:0] rd_q;
	logic          mem_wr;
	logic [EW-1:0] mem_wdata;

	logic          out_valid_q;
	res_item_t     out_q;

	logic [IW-1:0] char_mod [256];
	logic [7:0]    ch_lc;
	logic [IW:0]   hash_sum;
	logic [IW-1:0] hash_next;
	logic [IW-1:0] pos_inc;
	logic [31:0]   n_plus;
	logic [31:0]   pos_ext;
	logic          out_free;

	// byte value reduced modulo the table size
	for (genvar g = 0; g < 256; g++) begin : g_char_mod
		assign char_mod[g] = IW'(g % TABLE_SIZE);
	end

	always_comb begin
		if (key_item.ch >= CHAR_UPPER_A && key_item.ch <= CHAR_UPPER_Z) begin
			ch_lc = key_item.ch + CASE_OFFSET;
		end else begin
			ch_lc = key_item.ch;
		end
		hash_sum = {1'b0, hash_q} + {1'b0, char_mod[ch_lc]};
		if (hash_sum >= TSIZE_EXT) begin
			hash_next = IW'(hash_sum - TSIZE_EXT);
		end else begin
			hash_next = hash_sum[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q       <= OP_INSERT;
			too_long_q <= 1'b0;
			cnt_q      <= '0;
			hash_q     <= '0;
			key_buf_q  <= '0;
		end else if (cmd.emit) begin
			op_q       <= OP_INSERT;
			too_long_q <= 1'b0;
			cnt_q      <= '0;
			hash_q     <= '0;
			key_buf_q  <= '0;
		end else if (cmd.collect) begin
			if (cnt_q == '0) begin
				op_q <= key_item.op;
			end
			if (cnt_q < CW'(KEY_CHARS)) begin
				cnt_q  <= cnt_q + 1'b1;
				hash_q <= hash_next;
				for (int i = 0; i < KEY_CHARS; i++) begin
					if (cnt_q == CW'(i)) begin
						key_buf_q[8*i +: 8] <= key_item.ch;
					end
				end
			end else begin
				too_long_q <= 1'b1;
			end
		end
	end

	assign pos_inc = (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			n_q   <= '0;
		end else if (cmd.probe_load) begin
			pos_q <= hash_q;
			n_q   <= '0;
		end else if (cmd.probe_adv) begin
			pos_q <= pos_inc;
			n_q   <= n_q + 1'b1;
		end else if (cmd.clr_wr) begin
			pos_q <= pos_inc;
		end
	end

	// entry is {used, key}; the sweep after reset writes zero entries
	assign mem_wr    = cmd.clr_wr | cmd.key_wr;
	assign mem_wdata = cmd.key_wr ? {1'b1, key_buf_q} : '0;

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem_q[pos_q] <= mem_wdata;
		end
		rd_q <= mem_q[pos_q];
	end

	assign n_plus   = 32'(n_q) + 32'd1;
	assign pos_ext  = 32'(pos_q);
	assign out_free = !out_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.status <= cmd.status;
			out_q.probe_length <= (cmd.status == ST_FOUND) ? n_plus[7:0] : 8'd0;
			if (cmd.status == ST_FOUND || cmd.status == ST_INSERTED) begin
				out_q.slot <= pos_ext[6:0];
			end else begin
				out_q.slot <= 7'd0;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res_item  = out_q;

	assign sts.clr_last   = (pos_q == LAST_IDX);
	assign sts.too_long   = too_long_q;
	assign sts.op         = op_q;
	assign sts.used       = rd_q[KW];
	assign sts.match      = (rd_q[KW-1:0] == key_buf_q);
	assign sts.probe_last = (n_q == LAST_IDX);
	assign sts.out_free   = out_free;

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result issued while result register is held");

	a_emit_clears_collector: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (cnt_q == '0 && !too_long_q && res_valid))
		else $error("collector not cleared after result");

	a_load_not_during_collect: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe_load |-> !cmd.collect && !too_long_q)
		else $error("probe started on an over-long key");

endmodule

`default_nettype wire

/* design/lpsht_ctrl.sv */
// ----------------------------------------------------------------------------
// lpsht_ctrl
// Sequencer: reset sweep, character collection, and the probe walk.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsht_ctrl
	import lpsht_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic key_valid,
	input  wire logic key_last,
	output logic      key_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [4:0] {
		S_CLEAR   = 5'b00001,
		S_COLLECT = 5'b00010,
		S_DECIDE  = 5'b00100,
		S_READ    = 5'b01000,
		S_CHECK   = 5'b10000
	} state_t;

	state_t st_q;
	state_t st_next;

	always_comb begin
		cmd        = '0;
		cmd.status = ST_INSERTED;
		st_next    = st_q;
		key_stall  = 1'b1;
		case (st_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					st_next = S_COLLECT;
				end
			end
			S_COLLECT: begin
				key_stall = 1'b0;
				if (key_valid) begin
					cmd.collect = 1'b1;
					if (key_last) begin
						st_next = S_DECIDE;
					end
				end
			end
			S_DECIDE: begin
				if (sts.too_long) begin
					if (sts.out_free) begin
						cmd.emit   = 1'b1;
						cmd.status = ST_TOO_LONG;
						st_next    = S_COLLECT;
					end
				end else begin
					cmd.probe_load = 1'b1;
					st_next        = S_READ;
				end
			end
			S_READ: begin
				st_next = S_CHECK;
			end
			S_CHECK: begin
				if (sts.op == OP_INSERT) begin
					if (!sts.used) begin
						if (sts.out_free) begin
							cmd.key_wr = 1'b1;
							cmd.emit   = 1'b1;
							cmd.status = ST_INSERTED;
							st_next    = S_COLLECT;
						end
					end else if (sts.probe_last) begin
						if (sts.out_free) begin
							cmd.emit   = 1'b1;
							cmd.status = ST_FULL;
							st_next    = S_COLLECT;
						end
					end else begin
						cmd.probe_adv = 1'b1;
						st_next       = S_READ;
					end
				end else begin
					if (!sts.used || (!sts.match && sts.probe_last)) begin
						if (sts.out_free) begin
							cmd.emit   = 1'b1;
							cmd.status = ST_NOT_FOUND;
							st_next    = S_COLLECT;
						end
					end else if (sts.match) begin
						if (sts.out_free) begin
							cmd.emit   = 1'b1;
							cmd.status = ST_FOUND;
							st_next    = S_COLLECT;
						end
					end else begin
						cmd.probe_adv = 1'b1;
						st_next       = S_READ;
					end
				end
			end
			default: begin
				st_next = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR;
		end else begin
			st_q <= st_next;
		end
	end

	a_write_only_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.key_wr |-> (!sts.used && sts.op == OP_INSERT))
		else $error("key written over an occupied slot");

	a_advance_only_when_used: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe_adv |-> (sts.used && !sts.probe_last))
		else $error("probe advanced past an empty slot or the table end");

	a_last_starts_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_COLLECT && key_valid && key_last) |=> st_q == S_DECIDE)
		else $error("last character did not start the lookup");

endmodule

`default_nettype wire

/* design/linear_probe_string_hash_table.sv */
// ----------------------------------------------------------------------------
// linear_probe_string_hash_table
// Open addressing string hash table with linear probing.
// ----------------------------------------------------------------------------
// Keys arrive on the key channel one character per transfer, op taken from
// the first character, last marking the end. The result channel carries one
// result per key: status, probe length (1-based, zero unless found) and slot.
// After the last character comes a decide step, then each probe is a slot
// memory read followed by a check against the collected key, up to
// TABLE_SIZE probes; the result is registered at the end of the deciding
// check and is valid the next cycle, when the next key's first character
// can already be taken. Each probe uses the single read port of the slot
// memory; an over-long key goes from the decide step straight to its result.
// After reset the slot memory is swept clear, one slot per cycle, from slot
// 0 to TABLE_SIZE - 1; key_stall is high during the sweep.
// When the receiver stalls, a finished result waits in the output register
// and characters of the next key are still taken; the walk holds at its
// final check until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_string_hash_table
	import lpsht_pkg::*;
#(
	parameter int TABLE_SIZE = 128,
	parameter int KEY_CHARS  = 14
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      key_valid,
	output logic           key_stall,
	input  wire key_item_t key_item,
	output logic           res_valid,
	input  wire logic      res_stall,
	output res_item_t      res_item
);

	cmd_t cmd;
	sts_t sts;

	lpsht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.key_last  (key_item.last),
		.key_stall (key_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lpsht_dp #(
		.TABLE_SIZE (TABLE_SIZE),
		.KEY_CHARS  (KEY_CHARS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_item  (key_item),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res_item  (res_item),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire
